// ===== design/prq_pkg.sv =====
package prq_pkg;

    localparam int TASK_W = 8;
    localparam int PRI_W  = 6;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_RAISE  = 2'd2,
        ACT_CHECK  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_SHIFT  = 3'd2,
        CMD_MATCH  = 3'd3,
        CMD_SCAN   = 3'd4,
        CMD_REMOVE = 3'd5
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd           cmd;
        logic [TASK_W-1:0]   task_id;
        logic [PRI_W-1:0]    pri;
    } t_cell_ctrl;

    typedef struct packed {
        logic [TASK_W-1:0]   task_id;
        logic [PRI_W-1:0]    pri;
        logic                preempt;
        t_status             status;
    } t_result;

endpackage

// ===== design/prq_in_if.sv =====
interface prq_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [prq_pkg::TASK_W-1:0]  task_id;
    logic [prq_pkg::PRI_W-1:0]   priority_req;

    modport source (output valid, output action, output task_id, output priority_req,
                    input ready);
    modport sink (input valid, input action, input task_id, input priority_req,
                  output ready);
endinterface

// ===== design/prq_out_if.sv =====
interface prq_out_if;
    logic                        valid;
    logic                        ready;
    logic [prq_pkg::TASK_W-1:0]  out_task_id;
    logic [prq_pkg::PRI_W-1:0]   out_priority;
    logic                        preempt;
    logic [1:0]                  status;
    logic [prq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output out_task_id, output out_priority,
                    output preempt, output status, output occupancy, input ready);
    modport sink (input valid, input out_task_id, input out_priority,
                  input preempt, input status, input occupancy, output ready);
endinterface

// ===== design/prq_cell.sv =====
module prq_cell (
    input  logic                        i_clk,
    input  prq_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_valid,
    input  logic                        i_left_ge,
    input  logic [prq_pkg::TASK_W-1:0]  i_left_task,
    input  logic [prq_pkg::PRI_W-1:0]   i_left_pri,
    input  logic                        i_left_mark,
    input  logic [prq_pkg::TASK_W-1:0]  i_right_task,
    input  logic [prq_pkg::PRI_W-1:0]   i_right_pri,
    input  logic                        i_far_mark,
    output logic [prq_pkg::TASK_W-1:0]  o_task,
    output logic [prq_pkg::PRI_W-1:0]   o_pri,
    output logic                        o_ge,
    output logic                        o_mark,
    output logic                        o_hit
);

    logic [prq_pkg::TASK_W-1:0] r_task, n_task;
    logic [prq_pkg::PRI_W-1:0]  r_pri, n_pri;
    logic                       r_mark, n_mark;

    // The queue is sorted, so the cells at or above the new priority form a prefix.
    assign o_ge   = i_valid && (r_pri >= i_ctrl.pri);
    assign o_task = r_task;
    assign o_pri  = r_pri;
    assign o_mark = r_mark;
    // Only the first marked cell of the chain can raise its entry.
    assign o_hit  = r_mark && !i_left_mark && (i_ctrl.pri > r_pri);

    always_comb begin
        n_task = r_task;
        n_pri  = r_pri;
        n_mark = r_mark;
        unique case (i_ctrl.cmd)
            prq_pkg::CMD_HOLD: begin
            end
            prq_pkg::CMD_INSERT: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_task = i_ctrl.task_id;
                        n_pri  = i_ctrl.pri;
                    end else begin
                        n_task = i_left_task;
                        n_pri  = i_left_pri;
                    end
                end
            end
            prq_pkg::CMD_SHIFT: begin
                n_task = i_right_task;
                n_pri  = i_right_pri;
            end
            prq_pkg::CMD_MATCH: begin
                n_mark = i_valid && (r_task == i_ctrl.task_id);
            end
            prq_pkg::CMD_SCAN: begin
                n_mark = r_mark | i_far_mark;
            end
            prq_pkg::CMD_REMOVE: begin
                if (r_mark) begin
                    n_task = i_right_task;
                    n_pri  = i_right_pri;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        r_pri  <= n_pri;
        r_mark <= n_mark;
    end

endmodule

// ===== design/priority_ready_queue.sv =====
// Insert, pop and preemption check: the input beat passes through the execute and done states,
// then the result beat is loaded into the output register once it is free. A raise passes
// through the match, prefix scan, resolve, execute and done states, and skips the execute state
// when the id is missing or the priority is not higher. One item is in work at a time.
// A finished result waits in the output register while the next input beat is accepted.
// Synchronous active-low reset empties the queue; no clearing pass over the cells is needed.
module priority_ready_queue #(
    parameter int QUEUE_DEPTH     = 64,
    parameter int PRIORITY_LEVELS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_in_if.sink    i_req,
    prq_out_if.source o_rsp
);

    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SCAN_STEPS = $clog2(QUEUE_DEPTH);
    localparam int STEP_W     = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;
    localparam int PRI_MAX    = PRIORITY_LEVELS - 1;
    localparam int TW         = prq_pkg::TASK_W;
    localparam int PW         = prq_pkg::PRI_W;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MATCH   = 6'b000010,
        S_SCAN    = 6'b000100,
        S_RESOLVE = 6'b001000,
        S_EXEC    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [1:0]           r_op, n_op;
    logic [TW-1:0]        r_id, n_id;
    logic [PW-1:0]        r_pri, n_pri;
    prq_pkg::t_result     r_res, n_res;

    logic                 r_out_valid;
    prq_pkg::t_result     r_out;
    logic [CNT_W-1:0]     r_out_occ;

    prq_pkg::t_cell_ctrl  w_ctrl;
    prq_pkg::t_cell_cmd   w_cmd;
    logic [PW-1:0]        w_pri_clamped;
    logic                 w_accept;
    logic                 w_out_free;

    logic [TW-1:0]        w_task [QUEUE_DEPTH];
    logic [PW-1:0]        w_cpri [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_ge;
    logic [QUEUE_DEPTH-1:0] w_mark;
    logic [QUEUE_DEPTH-1:0] w_hit;

    // Priorities beyond the configured levels saturate to the top level.
    assign w_pri_clamped = (int'(i_req.priority_req) > PRI_MAX) ? PW'(PRI_MAX)
                                                                : i_req.priority_req;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_ctrl.cmd     = w_cmd;
    assign w_ctrl.task_id = r_id;
    assign w_ctrl.pri     = r_pri;

    // The chain of cells. Slot 0 is the head; a cell is occupied when its index
    // is below the entry count. Data moves one cell per cycle toward the tail on
    // an insert and toward the head on a pop or a removal.
    genvar gi, gk;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                  w_left_ge;
            logic [TW-1:0]         w_left_task;
            logic [PW-1:0]         w_left_pri;
            logic                  w_left_mark;
            logic [TW-1:0]         w_right_task;
            logic [PW-1:0]         w_right_pri;
            logic [SCAN_STEPS-1:0] w_far;

            assign w_valid[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_left_ge   = 1'b1;
                assign w_left_task = '0;
                assign w_left_pri  = '0;
                assign w_left_mark = 1'b0;
            end else begin : g_body
                assign w_left_ge   = w_ge[gi-1];
                assign w_left_task = w_task[gi-1];
                assign w_left_pri  = w_cpri[gi-1];
                assign w_left_mark = w_mark[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right_task = '0;
                assign w_right_pri  = '0;
            end else begin : g_inner
                assign w_right_task = w_task[gi+1];
                assign w_right_pri  = w_cpri[gi+1];
            end

            // Prefix scan taps: step k brings in the mark from 2**k cells headward.
            for (gk = 0; gk < SCAN_STEPS; gk++) begin : g_tap
                if (gi >= (1 << gk)) begin : g_on
                    assign w_far[gk] = w_mark[gi-(1<<gk)];
                end else begin : g_off
                    assign w_far[gk] = 1'b0;
                end
            end

            prq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_valid      (w_valid[gi]),
                .i_left_ge    (w_left_ge),
                .i_left_task  (w_left_task),
                .i_left_pri   (w_left_pri),
                .i_left_mark  (w_left_mark),
                .i_right_task (w_right_task),
                .i_right_pri  (w_right_pri),
                .i_far_mark   (w_far[r_step]),
                .o_task       (w_task[gi]),
                .o_pri        (w_cpri[gi]),
                .o_ge         (w_ge[gi]),
                .o_mark       (w_mark[gi]),
                .o_hit        (w_hit[gi])
            );
        end
    endgenerate

    // Sequencer. Insert, pop and check finish in the execute state. A raise first
    // marks every cell holding the id, turns the marks into an inclusive prefix
    // over log2(depth) scan steps and, if the new priority is higher, removes the first
    // marked entry by pulling the tail headward and re-inserts it at its new priority.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_step  = r_step;
        n_op    = r_op;
        n_id    = r_id;
        n_pri   = r_pri;
        n_res   = r_res;
        w_cmd   = prq_pkg::CMD_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_req.action;
                    n_id    = i_req.task_id;
                    n_pri   = w_pri_clamped;
                    n_state = (i_req.action == prq_pkg::ACT_RAISE) ? S_MATCH : S_EXEC;
                end
            end
            S_MATCH: begin
                w_cmd   = prq_pkg::CMD_MATCH;
                n_step  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_cmd = prq_pkg::CMD_SCAN;
                if (r_step == STEP_W'(SCAN_STEPS - 1)) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_RESOLVE: begin
                n_res.task_id = '0;
                n_res.pri     = '0;
                n_res.preempt = 1'b0;
                n_res.status  = prq_pkg::ST_OK;
                if (!w_mark[QUEUE_DEPTH-1]) begin
                    // The prefix is clear at the tail: the id is not queued.
                    n_res.status = prq_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (|w_hit) begin
                    w_cmd   = prq_pkg::CMD_REMOVE;
                    n_count = r_count - 1'b1;
                    n_state = S_EXEC;
                end else begin
                    // Found, but the new priority is not higher.
                    n_state = S_DONE;
                end
            end
            S_EXEC: begin
                n_res.task_id = '0;
                n_res.pri     = '0;
                n_res.preempt = 1'b0;
                n_res.status  = prq_pkg::ST_OK;
                unique case (r_op)
                    prq_pkg::ACT_INSERT: begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_res.status = prq_pkg::ST_FULL;
                        end else begin
                            w_cmd   = prq_pkg::CMD_INSERT;
                            n_count = r_count + 1'b1;
                        end
                    end
                    prq_pkg::ACT_POP: begin
                        if (r_count == '0) begin
                            n_res.status = prq_pkg::ST_EMPTY;
                        end else begin
                            n_res.task_id = w_task[0];
                            n_res.pri     = w_cpri[0];
                            w_cmd         = prq_pkg::CMD_SHIFT;
                            n_count       = r_count - 1'b1;
                        end
                    end
                    prq_pkg::ACT_RAISE: begin
                        // The entry was removed in the previous cycle; put it back.
                        w_cmd   = prq_pkg::CMD_INSERT;
                        n_count = r_count + 1'b1;
                    end
                    prq_pkg::ACT_CHECK: begin
                        n_res.preempt = w_valid[0] && (w_cpri[0] > r_pri);
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_id  <= n_id;
        r_pri <= n_pri;
        r_res <= n_res;
    end

    // Output register: the result beat is held here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out     <= r_res;
            r_out_occ <= r_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.out_task_id  = r_out.task_id;
    assign o_rsp.out_priority = r_out.pri;
    assign o_rsp.preempt      = r_out.preempt;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.occupancy    = prq_pkg::OCC_W'(r_out_occ);

    // The entry count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // After the prefix scan, at most one cell is the first match.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE) |-> $onehot0(w_hit))
        else $error("more than one first match after scan");

    // A full status is only reported with a full queue.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == prq_pkg::ST_FULL)
            |-> (r_out_occ == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with room left");

    // A raise removes an entry only to insert it again in the next cycle.
    a_raise_reinsert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE && w_cmd == prq_pkg::CMD_REMOVE)
            |=> (r_state == S_EXEC && r_op == prq_pkg::ACT_RAISE))
        else $error("removed entry not reinserted");

    // Occupied cells stay in descending priority order.
    generate
        for (gi = 0; gi + 1 < QUEUE_DEPTH; gi++) begin : g_order_chk
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_valid[gi+1] |-> (w_cpri[gi] >= w_cpri[gi+1]))
                else $error("queue order broken");
        end
    endgenerate

endmodule
